// ----- hdl/distance_lod_classifier_unit_defines.svh -----
`ifndef DISTANCE_LOD_CLASSIFIER_UNIT_DEFINES_SVH
`define DISTANCE_LOD_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define DLC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("dlc check failed");

// next-cycle implication
`define DLC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("dlc check failed");

`endif

// ----- hdl/dlc_pkg.sv -----
package dlc_pkg;

	localparam int MAX_ENTITIES = 65536;
	localparam int COORD_W      = 24;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int SQ_W         = 2 * COORD_W;
	localparam int SUM_W        = SQ_W + 2;
	localparam int ROOT_W       = SUM_W / 2;
	localparam int LIMIT_W      = 25;
	localparam int CNT_W        = 17;
	localparam int IDX_W        = 3;
	localparam int DATA_W       = 25;

	localparam int CNT_FULL    = 2 ** CNT_W - 1;
	localparam int CNT_CAP_INT = (MAX_ENTITIES < CNT_FULL) ? MAX_ENTITIES : CNT_FULL;
	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_INT);

	localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST   = LIMIT_W'(5120);
	localparam logic [LIMIT_W-1:0] MEDIUM_LIMIT_RST = LIMIT_W'(12800);
	localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST    = LIMIT_W'(25600);

	typedef enum logic [IDX_W-1:0] {
		REG_CAMERA_X     = 3'd0,
		REG_CAMERA_Y     = 3'd1,
		REG_CAMERA_Z     = 3'd2,
		REG_HIGH_LIMIT   = 3'd3,
		REG_MEDIUM_LIMIT = 3'd4,
		REG_LOW_LIMIT    = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		LVL_HIGH   = 2'd0,
		LVL_MEDIUM = 2'd1,
		LVL_LOW    = 2'd2,
		LVL_CULLED = 2'd3
	} level_t;

	typedef struct packed {
		logic                      first_of_frame;
		logic                      eligible;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [1:0]                prev_level;
	} entity_t;

	typedef struct packed {
		logic               applied;
		logic [1:0]         level;
		logic [LIMIT_W-1:0] distance;
		logic               visible;
		logic               level_changed;
		logic [CNT_W-1:0]   processed_count;
		logic [CNT_W-1:0]   high_count;
		logic [CNT_W-1:0]   medium_count;
		logic [CNT_W-1:0]   low_count;
		logic [CNT_W-1:0]   culled_count;
		logic [CNT_W-1:0]   switch_count;
	} result_t;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c, input logic en);
		return (en && (c < CNT_CAP)) ? c + CNT_W'(1) : c;
	endfunction

endpackage

// ----- hdl/dlc_entity_if.sv -----
interface dlc_entity_if;
	logic             valid;
	logic             ready;
	dlc_pkg::entity_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/dlc_result_if.sv -----
interface dlc_result_if;
	logic             valid;
	logic             ready;
	dlc_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/dlc_isqrt.sv -----
module dlc_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dlc_pkg::SUM_W-1:0]   radicand,
	output logic                        done,
	output logic [dlc_pkg::ROOT_W-1:0]  root
);

	localparam int CNT_W  = $clog2(dlc_pkg::ROOT_W);
	localparam int REM_W  = dlc_pkg::ROOT_W + 1;
	localparam int SH_W   = REM_W + 2;
	localparam int TRY_W  = SH_W + 1;

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [dlc_pkg::SUM_W-1:0]   rad_q;
	logic [REM_W-1:0]            rem_q;
	logic [dlc_pkg::ROOT_W-1:0]  root_q;

	logic [SH_W-1:0]  rem_sh;
	logic [TRY_W-1:0] trial;

	// two radicand bits enter the partial remainder each cycle while the unit is busy
	assign rem_sh = {rem_q, rad_q[dlc_pkg::SUM_W-1 -: 2]};
	assign trial  = {1'b0, rem_sh} - {2'b00, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(dlc_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (!trial[TRY_W-1]) begin
				rem_q  <= trial[REM_W-1:0];
				root_q <= {root_q[dlc_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[REM_W-1:0];
				root_q <= {root_q[dlc_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- hdl/distance_lod_classifier_unit.sv -----
// Distance LOD classifier: one entity per transaction, one result per entity, one entity
// in flight at a time (entity.ready is high only while idle). For an eligible entity
// S_SQ squares and sums the three axis offsets on one 24x24 multiplier, then in S_ROOT
// a radix-4 square-root unit retires one root bit per cycle until all 25 root bits are
// done and hands the root back, then S_CLASS classifies and updates the frame counters
// and S_OUT raises result.valid. An ineligible entity skips the arithmetic and goes
// from acceptance straight to S_CLASS, then S_OUT. The result holds until taken; the next
// entity is accepted the cycle after. Register writes are applied on any cycle with wr_en.
module distance_lod_classifier_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	dlc_entity_if.sink                    entity,
	dlc_result_if.source                  result,
	input  logic                          wr_en,
	input  logic [dlc_pkg::IDX_W-1:0]     wr_index,
	input  logic [dlc_pkg::DATA_W-1:0]    wr_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQ,
		S_ROOT,
		S_CLASS,
		S_OUT
	} state_t;

	state_t state_q;
	logic [1:0] axis_q;

	logic signed [dlc_pkg::COORD_W-1:0] cam_x_q, cam_y_q, cam_z_q;
	logic [dlc_pkg::LIMIT_W-1:0]        high_lim_q, med_lim_q, low_lim_q;

	dlc_pkg::entity_t           ent_q;
	logic [dlc_pkg::SQ_W-1:0]   prod_q;
	logic [dlc_pkg::SUM_W-1:0]  acc_q;
	dlc_pkg::result_t           res_q;

	logic [dlc_pkg::CNT_W-1:0] proc_cnt_q, high_cnt_q, med_cnt_q, low_cnt_q;
	logic [dlc_pkg::CNT_W-1:0] cull_cnt_q, sw_cnt_q;

	logic signed [dlc_pkg::COORD_W-1:0] pos_sel, cam_sel;
	logic signed [dlc_pkg::DIFF_W-1:0]  diff;
	logic [dlc_pkg::COORD_W-1:0]        mag;
	logic [dlc_pkg::SUM_W-1:0]          sum;
	logic                               sq_start;
	logic                               sq_done;
	logic [dlc_pkg::ROOT_W-1:0]         root;

	logic [dlc_pkg::LIMIT_W-1:0] lod_dist;
	dlc_pkg::level_t             lvl;
	logic                        changed;
	logic                        elig;
	logic [dlc_pkg::CNT_W-1:0]   base_proc, base_high, base_med, base_low, base_cull, base_sw;

	always_comb begin
		unique case (axis_q)
			2'd0: begin
				pos_sel = ent_q.pos_x;
				cam_sel = cam_x_q;
			end
			2'd1: begin
				pos_sel = ent_q.pos_y;
				cam_sel = cam_y_q;
			end
			default: begin
				pos_sel = ent_q.pos_z;
				cam_sel = cam_z_q;
			end
		endcase
	end

	assign diff = dlc_pkg::DIFF_W'(pos_sel) - dlc_pkg::DIFF_W'(cam_sel);
	assign mag  = diff[dlc_pkg::DIFF_W-1] ? dlc_pkg::COORD_W'(-diff) : diff[dlc_pkg::COORD_W-1:0];
	assign sum  = acc_q + dlc_pkg::SUM_W'(prod_q);

	assign sq_start = (state_q == S_SQ) && (axis_q == 2'd3);

	dlc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sum),
		.done     (sq_done),
		.root     (root)
	);

	always_comb begin
		elig = ent_q.eligible;
		lod_dist = elig ? dlc_pkg::LIMIT_W'(root) : '0;
		priority if (lod_dist <= high_lim_q)
			lvl = dlc_pkg::LVL_HIGH;
		else if (lod_dist <= med_lim_q)
			lvl = dlc_pkg::LVL_MEDIUM;
		else if (lod_dist <= low_lim_q)
			lvl = dlc_pkg::LVL_LOW;
		else
			lvl = dlc_pkg::LVL_CULLED;
		if (!elig)
			lvl = dlc_pkg::LVL_HIGH;
		changed   = elig && (lvl != dlc_pkg::level_t'(ent_q.prev_level));
		base_proc = ent_q.first_of_frame ? '0 : proc_cnt_q;
		base_high = ent_q.first_of_frame ? '0 : high_cnt_q;
		base_med  = ent_q.first_of_frame ? '0 : med_cnt_q;
		base_low  = ent_q.first_of_frame ? '0 : low_cnt_q;
		base_cull = ent_q.first_of_frame ? '0 : cull_cnt_q;
		base_sw   = ent_q.first_of_frame ? '0 : sw_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q    <= '0;
			cam_y_q    <= '0;
			cam_z_q    <= '0;
			high_lim_q <= dlc_pkg::HIGH_LIMIT_RST;
			med_lim_q  <= dlc_pkg::MEDIUM_LIMIT_RST;
			low_lim_q  <= dlc_pkg::LOW_LIMIT_RST;
		end else if (wr_en) begin
			unique case (dlc_pkg::reg_idx_t'(wr_index))
				dlc_pkg::REG_CAMERA_X:     cam_x_q    <= wr_data[dlc_pkg::COORD_W-1:0];
				dlc_pkg::REG_CAMERA_Y:     cam_y_q    <= wr_data[dlc_pkg::COORD_W-1:0];
				dlc_pkg::REG_CAMERA_Z:     cam_z_q    <= wr_data[dlc_pkg::COORD_W-1:0];
				dlc_pkg::REG_HIGH_LIMIT:   high_lim_q <= wr_data[dlc_pkg::LIMIT_W-1:0];
				dlc_pkg::REG_MEDIUM_LIMIT: med_lim_q  <= wr_data[dlc_pkg::LIMIT_W-1:0];
				dlc_pkg::REG_LOW_LIMIT:    low_lim_q  <= wr_data[dlc_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && entity.valid) begin
			ent_q <= entity.payload;
			acc_q <= '0;
		end else if (state_q == S_SQ) begin
			if (axis_q != 2'd0)
				acc_q <= sum;
			if (axis_q != 2'd3)
				prod_q <= mag * mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			axis_q     <= '0;
			res_q      <= '0;
			proc_cnt_q <= '0;
			high_cnt_q <= '0;
			med_cnt_q  <= '0;
			low_cnt_q  <= '0;
			cull_cnt_q <= '0;
			sw_cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					axis_q <= '0;
					if (entity.valid)
						state_q <= entity.payload.eligible ? S_SQ : S_CLASS;
				end
				S_SQ: begin
					axis_q <= axis_q + 2'd1;
					if (axis_q == 2'd3)
						state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (sq_done)
						state_q <= S_CLASS;
				end
				S_CLASS: begin
					proc_cnt_q <= dlc_pkg::bump(base_proc, elig);
					high_cnt_q <= dlc_pkg::bump(base_high, elig && lvl == dlc_pkg::LVL_HIGH);
					med_cnt_q  <= dlc_pkg::bump(base_med, elig && lvl == dlc_pkg::LVL_MEDIUM);
					low_cnt_q  <= dlc_pkg::bump(base_low, elig && lvl == dlc_pkg::LVL_LOW);
					cull_cnt_q <= dlc_pkg::bump(base_cull, elig && lvl == dlc_pkg::LVL_CULLED);
					sw_cnt_q   <= dlc_pkg::bump(base_sw, changed);
					res_q.applied         <= elig;
					res_q.level           <= lvl;
					res_q.distance        <= lod_dist;
					res_q.visible         <= elig && (lvl != dlc_pkg::LVL_CULLED);
					res_q.level_changed   <= changed;
					res_q.processed_count <= dlc_pkg::bump(base_proc, elig);
					res_q.high_count      <= dlc_pkg::bump(base_high,
						elig && lvl == dlc_pkg::LVL_HIGH);
					res_q.medium_count    <= dlc_pkg::bump(base_med,
						elig && lvl == dlc_pkg::LVL_MEDIUM);
					res_q.low_count       <= dlc_pkg::bump(base_low,
						elig && lvl == dlc_pkg::LVL_LOW);
					res_q.culled_count    <= dlc_pkg::bump(base_cull,
						elig && lvl == dlc_pkg::LVL_CULLED);
					res_q.switch_count    <= dlc_pkg::bump(base_sw, changed);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (result.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign entity.ready   = (state_q == S_IDLE);
	assign result.valid   = (state_q == S_OUT);
	assign result.payload = res_q;

endmodule

// ----- hdl/dlc_checker.sv -----
`include "distance_lod_classifier_unit_defines.svh"

module dlc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          entity_valid,
	input logic                          entity_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic                          applied,
	input logic                          visible,
	input logic [1:0]                    level,
	input logic [dlc_pkg::LIMIT_W-1:0]   distance
);

	`DLC_ASSERT_NEXT(a_no_instant_result, entity_valid && entity_ready, !result_valid)

	`DLC_ASSERT_NOW(a_one_in_flight, result_valid, !entity_ready)

	`DLC_ASSERT_NOW(a_skipped_clean, result_valid && !applied,
		level == dlc_pkg::LVL_HIGH && distance == '0 && !visible)

	`DLC_ASSERT_NEXT(a_result_holds, result_valid && !result_ready,
		result_valid && $stable(distance) && $stable(level))

endmodule

bind distance_lod_classifier_unit dlc_checker u_dlc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.entity_valid (entity.valid),
	.entity_ready (entity.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.applied      (result.payload.applied),
	.visible      (result.payload.visible),
	.level        (result.payload.level),
	.distance     (result.payload.distance)
);
